@@ hdl/cgio_pkg.sv @@
`timescale 1ns / 1ps

package cgio_pkg;

    // Default sizing of the detector.
    localparam int STAFF_COUNT_DEF = 4;
    localparam int VOICE_COUNT_DEF = 8;
    localparam int NOTE_SLOTS_DEF  = 64;

    // Fixed field widths.
    localparam int TICK_W  = 31;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;

    // Command codes of the mode field; the fourth code does nothing.
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TICK_W-1:0]  start_tick;
        logic [TICK_W-1:0]  end_tick;
        logic [INDEX_W-1:0] voice_index;
        logic [INDEX_W-1:0] staff_index;
    } cmd_t;

    typedef struct packed {
        logic voice_overlaps;
        logic note_dropped;
    } rsp_t;

    // Port of the note store, driven by the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

@@ hdl/cgio_note_mem.sv @@
`timescale 1ns / 1ps

// Note store: one entry per slot holding start, end and staff. Synchronous
// read into one data register; the overlap test runs on the read data.
module cgio_note_mem #(
    parameter int DEPTH   = 512,
    parameter int ADDR_W  = 9,
    parameter int STAFF_W = 2
) (
    input  logic                  clk,
    input  cgio_pkg::mem_ctl_t    ctl,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  cgio_pkg::cmd_t        item,
    output logic                  hit
);

    localparam int TICK_W  = cgio_pkg::TICK_W;
    localparam int ENTRY_W = 2 * TICK_W + STAFF_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [TICK_W-1:0]  rd_start;
    logic [TICK_W-1:0]  rd_end;
    logic [STAFF_W-1:0] rd_staff;
    logic [STAFF_W-1:0] item_staff;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= {item.start_tick, item.end_tick,
                             item.staff_index[STAFF_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_start   = rd_data_reg[ENTRY_W-1 -: TICK_W];
    assign rd_end     = rd_data_reg[STAFF_W +: TICK_W];
    assign rd_staff   = rd_data_reg[STAFF_W-1:0];
    assign item_staff = item.staff_index[STAFF_W-1:0];

    // Overlap: each note starts before the other ends, on different staves.
    assign hit = (rd_staff != item_staff) &&
                 (item.start_tick < rd_end) &&
                 (rd_start < item.end_tick);

endmodule

@@ hdl/cross_group_interval_overlap_top.sv @@
`timescale 1ns / 1ps

// Cross-staff overlap detector. Each command item adds a note interval to a
// voice, clears all voices at a new measure, or queries a voice; every item
// returns exactly one result item with the voice's sticky overlap flag and a
// dropped mark for an add that found the voice full. Notes live in one
// synchronous memory of VOICE_COUNT * NOTE_SLOTS entries with one read and
// one write port, never used together. An add reads the voice's stored notes
// one per cycle and tests each against the new note, then writes the new note
// behind them. In order, an add reads the stored notes, tests the last read
// data, sees the scan finished, writes the note and loads the result; an add
// into an empty voice skips the reads and the test. The slowest add is one
// into a voice holding NOTE_SLOTS - 1 notes, as the memory port gives one
// read per cycle. Clears, queries, ignored adds and full-voice adds go
// straight to the finishing state, which loads their result once the output
// register is free. One item is worked at a time: the input stalls until the
// result is loaded, and the next item can be taken in the cycle after, so a
// result that waits for the output register also holds off the input. A
// finished result waits in the output register while the next item is
// accepted. The note memory needs no clearing after reset: per-voice fill
// counts in flip-flops mark which slots hold notes.
module cross_group_interval_overlap_top #(
    parameter int STAFF_COUNT = cgio_pkg::STAFF_COUNT_DEF,
    parameter int VOICE_COUNT = cgio_pkg::VOICE_COUNT_DEF,
    parameter int NOTE_SLOTS  = cgio_pkg::NOTE_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,

    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  cgio_pkg::cmd_t cmd,

    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cgio_pkg::rsp_t rsp
);

    localparam int DEPTH   = VOICE_COUNT * NOTE_SLOTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int STAFF_W = $clog2(STAFF_COUNT);
    localparam int FILL_W  = $clog2(NOTE_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    cgio_pkg::cmd_t       item_reg, item_next;
    logic [VOICE_W-1:0]   voice_reg, voice_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [FILL_W-1:0]    fill_cur_reg, fill_cur_next;
    logic [FILL_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 hit_reg, hit_next;
    cgio_pkg::rsp_t       res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    cgio_pkg::rsp_t       rsp_reg, rsp_next;
    logic [FILL_W-1:0]    fill_reg [VOICE_COUNT];
    logic [FILL_W-1:0]    fill_next [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] flag_reg, flag_next;

    // Decode of the incoming item.
    logic                 voice_ok;
    logic                 staff_ok;
    logic [VOICE_W-1:0]   vidx;
    logic [FILL_W-1:0]    fill_sel;
    logic                 flag_sel;

    cgio_pkg::mem_ctl_t   mem_ctl;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 mem_hit;

    assign voice_ok = int'(cmd.voice_index) < VOICE_COUNT;
    assign staff_ok = int'(cmd.staff_index) < STAFF_COUNT;
    assign vidx     = voice_ok ? cmd.voice_index[VOICE_W-1:0] : '0;
    assign fill_sel = fill_reg[vidx];
    assign flag_sel = flag_reg[vidx];

    // Accept only between items; the result register decouples the output.
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rd_addr = base_reg + ADDR_W'(scan_cnt_reg);
    assign wr_addr = base_reg + ADDR_W'(fill_cur_reg);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        voice_next     = voice_reg;
        base_next      = base_reg;
        fill_cur_next  = fill_cur_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_pend_next   = 1'b0;
        hit_next       = hit_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        fill_next      = fill_reg;
        flag_next      = flag_reg;
        mem_ctl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next     = cmd;
                    voice_next    = vidx;
                    base_next     = ADDR_W'(int'(vidx) * NOTE_SLOTS);
                    fill_cur_next = fill_sel;
                    scan_cnt_next = '0;
                    hit_next      = 1'b0;
                    res_next      = '0;
                    state_next    = ST_DONE;
                    case (cmd.mode)
                        cgio_pkg::MODE_CLEAR:
                        begin
                            // New measure: drop every stored note and flag.
                            for (int v = 0; v < VOICE_COUNT; v++)
                            begin
                                fill_next[v] = '0;
                            end
                            flag_next = '0;
                        end
                        cgio_pkg::MODE_ADD:
                        begin
                            if (voice_ok)
                            begin
                                res_next.voice_overlaps = flag_sel;
                                if (!staff_ok)
                                begin
                                    // Staff out of range: store nothing.
                                    res_next.note_dropped = 1'b0;
                                end
                                else if (fill_sel == FILL_W'(NOTE_SLOTS))
                                begin
                                    // Voice full: drop the note unseen.
                                    res_next.note_dropped = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        cgio_pkg::MODE_QUERY:
                        begin
                            res_next.voice_overlaps = voice_ok && flag_sel;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; test the data of the last read.
                if (scan_cnt_reg != fill_cur_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                end
                if (rd_pend_reg && mem_hit)
                begin
                    hit_next = 1'b1;
                end
                if ((scan_cnt_reg == fill_cur_reg) && !rd_pend_reg)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                // Append the note behind the stored ones and merge the flag.
                mem_ctl.wr_en           = 1'b1;
                fill_next[voice_reg]    = fill_cur_reg + 1'b1;
                flag_next[voice_reg]    = flag_reg[voice_reg] | hit_reg;
                res_next.voice_overlaps = flag_reg[voice_reg] | hit_reg;
                res_next.note_dropped   = 1'b0;
                state_next              = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold the result until the output register frees up.
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flag_reg      <= '0;
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                fill_reg[v] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
            flag_reg      <= flag_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        voice_reg    <= voice_next;
        base_reg     <= base_next;
        fill_cur_reg <= fill_cur_next;
        scan_cnt_reg <= scan_cnt_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    cgio_note_mem #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .STAFF_W (STAFF_W)
    ) u_note_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .item    (item_reg),
        .hit     (mem_hit)
    );

    // A result appears only out of the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the finishing state");

    // The scan never runs past the voice's stored notes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= fill_cur_reg))
        else $error("scan ran past the fill count");

    // A note is written only into a free slot of its voice.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (fill_cur_reg < FILL_W'(NOTE_SLOTS)))
        else $error("note written into a full voice");

    // An accepted item always moves the sequencer out of its idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted item not taken up");

    // Writing and reading the store never coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("read and write of the note store in one cycle");

endmodule

@@ bench/tb_cross_group_interval_overlap_top.sv @@
`timescale 1ns / 1ps

// Bench for the cross-staff overlap detector. Every command item is run
// through a local model of the note store as it goes onto the bus, and the
// answer it must produce is queued. A monitor pops that queue for each result
// item the block hands over and compares the two flags.
module tb_cross_group_interval_overlap_top;

    localparam int STAFFS = cgio_pkg::STAFF_COUNT_DEF;
    localparam int VOICES = cgio_pkg::VOICE_COUNT_DEF;
    localparam int SLOTS  = cgio_pkg::NOTE_SLOTS_DEF;

    localparam int TICK_W  = cgio_pkg::TICK_W;
    localparam int MODE_W  = cgio_pkg::MODE_W;
    localparam int INDEX_W = cgio_pkg::INDEX_W;

    // The fourth mode code has no name in the package; the block ignores it.
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Long receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD = 400;
    // Allow for the slowest add, with margin.
    localparam int DRAIN_CYCLES = SLOTS + 8;
    // Items sent over the whole run, directed ones included.
    localparam int TOTAL_ITEMS = 900;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cgio_pkg::cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    cgio_pkg::rsp_t rsp;

    // Model of the note store, one row of slots per voice.
    logic [TICK_W-1:0]  note_start [VOICES][SLOTS];
    logic [TICK_W-1:0]  note_end   [VOICES][SLOTS];
    logic [INDEX_W-1:0] note_staff [VOICES][SLOTS];
    int                 note_fill  [VOICES];
    bit                 voice_flag [VOICES];

    cgio_pkg::rsp_t pending_answers [$];
    cgio_pkg::rsp_t want_rsp;

    int fail_count;
    int sent_items;
    int rsp_hold_left;
    bit calm;       // no new random idling on either side while set
    bit hold_req;   // ask the receiver for one long hold-off

    cross_group_interval_overlap_top #(
        .STAFF_COUNT(STAFFS),
        .VOICE_COUNT(VOICES),
        .NOTE_SLOTS (SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial
    begin
        #15000000;
        $display("cross_group_interval_overlap_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Note store model
    // ------------------------------------------------------------------

    // Drop every stored note and every overlap flag.
    function automatic void clear_notes();
        for (int v = 0; v < VOICES; v++)
        begin
            note_fill[v]  = 0;
            voice_flag[v] = 1'b0;
        end
    endfunction

    // Apply one command to the model and return the answer it must produce.
    function automatic cgio_pkg::rsp_t predict_overlap(cgio_pkg::cmd_t c);
        cgio_pkg::rsp_t r;
        int   v;
        int   f;
        r = '0;
        if (c.mode == cgio_pkg::MODE_CLEAR)
        begin
            clear_notes();
        end
        else if ((c.mode == cgio_pkg::MODE_ADD || c.mode == cgio_pkg::MODE_QUERY) &&
                 int'(c.voice_index) < VOICES)
        begin
            v = int'(c.voice_index);
            if (c.mode == cgio_pkg::MODE_ADD && int'(c.staff_index) < STAFFS)
            begin
                f = note_fill[v];
                if (f >= SLOTS)
                begin
                    // Full voice: neither stored nor compared.
                    r.note_dropped = 1'b1;
                end
                else
                begin
                    // Compare against notes of the same voice on other staves.
                    for (int k = 0; k < f; k++)
                    begin
                        if (note_staff[v][k] != c.staff_index &&
                            c.start_tick < note_end[v][k] &&
                            note_start[v][k] < c.end_tick)
                            voice_flag[v] = 1'b1;
                    end
                    note_start[v][f] = c.start_tick;
                    note_end[v][f]   = c.end_tick;
                    note_staff[v][f] = c.staff_index;
                    note_fill[v]     = f + 1;
                end
            end
            r.voice_overlaps = voice_flag[v];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic cgio_pkg::cmd_t make_cmd(input logic [MODE_W-1:0] m,
                                                input logic [TICK_W-1:0] s,
                                                input logic [TICK_W-1:0] e,
                                                input logic [INDEX_W-1:0] v,
                                                input logic [INDEX_W-1:0] f);
        cgio_pkg::cmd_t c;
        c.mode        = m;
        c.start_tick  = s;
        c.end_tick    = e;
        c.voice_index = v;
        c.staff_index = f;
        return c;
    endfunction

    function automatic logic [TICK_W-1:0] rand_tick();
        return TICK_W'($urandom);
    endfunction

    // Idle length: drawn from the short range most of the time, from the long one now and then.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // Put one item on the command bus and hold it until the block takes it.
    // The answer is queued as the item goes out; order alone matters.
    task automatic send_cmd(input cgio_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd       <= c;
        cmd_valid <= 1'b1;
        pending_answers.push_back(predict_overlap(c));
        sent_items++;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold_left--;
            end
            else if (hold_req)
            begin
                rsp_stall <= 1'b1;
                rsp_hold_left = LONG_HOLD - 1;
                hold_req = 1'b0;
            end
            else if (calm || $urandom_range(0, 3) != 0)
            begin
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= 1'b1;
                rsp_hold_left = idle_len() - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result item: voice_overlaps=%0b note_dropped=%0b",
                       rsp.voice_overlaps, rsp.note_dropped);
                fail_count++;
            end
            else
            begin
                want_rsp = pending_answers.pop_front();
                if (rsp.voice_overlaps !== want_rsp.voice_overlaps)
                begin
                    $error("voice_overlaps: expected %0b, got %0b",
                           want_rsp.voice_overlaps, rsp.voice_overlaps);
                    fail_count++;
                end
                if (rsp.note_dropped !== want_rsp.note_dropped)
                begin
                    $error("note_dropped: expected %0b, got %0b",
                           want_rsp.note_dropped, rsp.note_dropped);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked items: tick extremes, every mode, touching and reversed
    // intervals, staves out of range, and clearing.
    task automatic test_directed();
        send_cmd(make_cmd(cgio_pkg::MODE_CLEAR, '0, '0, 3'd0, 3'd0));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd0, 3'd0));
        // Same staff: never counts as overlap.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd10, 31'd20, 3'd0, 3'd0));
        // Empty interval at the top of the range meets nothing.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, TICK_MAX, TICK_MAX, 3'd0, 3'd1));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd0, 3'd0));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd20, 31'd30, 3'd0, 3'd1));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, TICK_MAX, TICK_MAX, 3'd0, 3'd7));
        // Touching intervals on different staves do not overlap.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd100, 31'd200, 3'd1, 3'd2));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd200, 31'd300, 3'd1, 3'd3));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd50, 31'd100, 3'd1, 3'd3));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd1, 3'd0));
        // Reversed interval, tested literally.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd199, 31'd150, 3'd1, 3'd3));
        // Staves past the last one are ignored.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd2, 3'd4));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd2, 3'd7));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd5, 31'd6, 3'd2, 3'd0));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd2, 3'd0));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, TICK_MAX - 31'd1, TICK_MAX, 3'd7, 3'd3));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd7, 3'd2));
        send_cmd(make_cmd(MODE_NOP, TICK_MAX, TICK_MAX, 3'd7, 3'd7));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd3, 3'd0));
        // Clear with every other field at its top value.
        send_cmd(make_cmd(cgio_pkg::MODE_CLEAR, TICK_MAX, TICK_MAX, 3'd7, 3'd7));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd0, 3'd0));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd7, 3'd0));
    endtask

    // Fill one voice to the last slot, then push past it; no random idling until the clear.
    task automatic test_voice_full();
        calm = 1'b1;
        send_cmd(make_cmd(cgio_pkg::MODE_CLEAR, '0, '0, 3'd0, 3'd0));
        for (int i = 0; i < SLOTS; i++)
            send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'(i * 10), 31'(i * 10 + 25),
                              3'd5, 3'd0));
        // Would overlap, but the voice is full: dropped and not compared.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd5, 3'd1));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'd3, 31'd4, 3'd5, 3'd3));
        // Out-of-range staff into a full voice is ignored, not dropped.
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd5, 3'd6));
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'd5, 3'd0));
        calm = 1'b0;
        send_cmd(make_cmd(cgio_pkg::MODE_CLEAR, '0, '0, 3'd0, 3'd0));
        send_cmd(make_cmd(cgio_pkg::MODE_ADD, '0, TICK_MAX, 3'd5, 3'd1));
    endtask

    // Hold the receiver off while items keep coming back to back.
    task automatic test_backpressure();
        calm = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            if (i % 3 == 0)
                send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'(i % VOICES), 3'd0));
            else
                send_cmd(make_cmd(cgio_pkg::MODE_ADD, 31'(i * 7), 31'(i * 7 + 12),
                                  3'(i % 2), 3'(i % STAFFS)));
        end
        calm = 1'b0;
    endtask

    // One measure: clear, then notes clustered in time on one or two voices
    // so that cross-staff overlaps are common; a few queries mixed in.
    task automatic play_measure();
        int                n_notes;
        int                voice_a;
        int                voice_b;
        int                r;
        logic [TICK_W-1:0] base;
        logic [TICK_W-1:0] st;
        logic [TICK_W-1:0] en;
        logic [INDEX_W-1:0] vc;
        logic [INDEX_W-1:0] sf;
        base = ($urandom_range(0, 3) == 0) ? TICK_MAX - 31'd700 : rand_tick();
        send_cmd(make_cmd(cgio_pkg::MODE_CLEAR, rand_tick(), rand_tick(),
                          INDEX_W'($urandom), INDEX_W'($urandom)));
        n_notes = $urandom_range(4, 40);
        voice_a = $urandom_range(0, VOICES - 1);
        voice_b = $urandom_range(0, VOICES - 1);
        for (int i = 0; i < n_notes; i++)
        begin
            vc = INDEX_W'(($urandom_range(0, 1) != 0) ? voice_a : voice_b);
            if ($urandom_range(0, 99) < 12)
            begin
                send_cmd(make_cmd(cgio_pkg::MODE_QUERY, rand_tick(), rand_tick(), vc,
                                  INDEX_W'($urandom)));
            end
            else
            begin
                st = base + 31'($urandom_range(0, 600));
                r  = $urandom_range(0, 99);
                if (r < 8)
                    en = st - 31'($urandom_range(0, 50));
                else
                    en = st + 31'($urandom_range(1, 150));
                if ($urandom_range(0, 9) == 0)
                    sf = INDEX_W'($urandom_range(STAFFS, 7));
                else
                    sf = INDEX_W'($urandom_range(0, STAFFS - 1));
                send_cmd(make_cmd(cgio_pkg::MODE_ADD, st, en, vc, sf));
            end
        end
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, 3'(voice_a), 3'd0));
    endtask

    // Run one voice into its slot limit with mostly one staff.
    task automatic fill_voice();
        int                 n_notes;
        logic [INDEX_W-1:0] vc;
        logic [INDEX_W-1:0] home;
        logic [INDEX_W-1:0] sf;
        logic [TICK_W-1:0]  st;
        send_cmd(make_cmd(cgio_pkg::MODE_CLEAR, '0, '0, 3'd0, 3'd0));
        vc      = INDEX_W'($urandom_range(0, VOICES - 1));
        home    = INDEX_W'($urandom_range(0, STAFFS - 1));
        n_notes = SLOTS + $urandom_range(1, 6);
        for (int i = 0; i < n_notes; i++)
        begin
            sf = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(0, STAFFS - 1)) : home;
            st = 31'(i * 40 + $urandom_range(0, 30));
            send_cmd(make_cmd(cgio_pkg::MODE_ADD, st, st + 31'($urandom_range(1, 60)),
                              vc, sf));
        end
        send_cmd(make_cmd(cgio_pkg::MODE_QUERY, '0, '0, vc, 3'd0));
    endtask

    // Fully random items, every mode code included.
    task automatic send_noise();
        int n;
        n = $urandom_range(3, 15);
        for (int i = 0; i < n; i++)
            send_cmd(make_cmd(MODE_W'($urandom), rand_tick(), rand_tick(),
                              INDEX_W'($urandom), INDEX_W'($urandom)));
    endtask

    // Random measures until the run has sent about its planned item count.
    task automatic test_random();
        int r;
        while (sent_items < TOTAL_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
                play_measure();
            else if (r < 86)
                fill_voice();
            else
                send_noise();
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        rsp_stall     = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        fail_count    = 0;
        sent_items    = 0;
        rsp_hold_left = 0;
        clear_notes();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_voice_full();
        test_backpressure();
        test_random();

        // Drop valid, drain the answers, then allow for stray results.
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("cross_group_interval_overlap_top: match");
        else
            $display("cross_group_interval_overlap_top: mismatch");
        $finish;
    end

endmodule
